// ===== hdl/sbf_pkg.sv =====
// Shared types, constants and codes of the serial-bus frame decoder.
`default_nettype none
package sbf_pkg;

  localparam int BYTE_W        = 8;
  localparam int CH_W          = 11;
  localparam int PWM_W         = 12;
  localparam int IDX_W         = 4;
  localparam int CFG_W         = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CNT_W         = 5;
  localparam int ADDR_W        = 5;
  localparam int CH_CNT_W      = 5;
  localparam int ACC_W         = 10;
  localparam int ACC_CNT_W     = 4;
  localparam int MERGE_W       = 18;
  localparam int PROD_W        = CH_W + PWM_W;

  localparam int FRAME_BYTES   = 25;
  localparam int BODY_DEPTH    = 23;
  localparam int PAYLOAD_BYTES = 22;
  localparam int NUM_CHANNELS_DEF = 16;

  localparam logic [CNT_W-1:0]  FULL_COUNT  = CNT_W'(FRAME_BYTES);
  localparam logic [CNT_W-1:0]  CLOSE_POS   = CNT_W'(FRAME_BYTES - 1);
  localparam logic [CNT_W-1:0]  BODY_LAST   = CNT_W'(BODY_DEPTH);
  localparam logic [ADDR_W-1:0] FLAGS_ADDR  = ADDR_W'(PAYLOAD_BYTES);
  localparam logic [ADDR_W-1:0] PAY_LAST    = ADDR_W'(PAYLOAD_BYTES - 1);
  localparam logic [CH_W-1:0]   CH_FULL     = 11'h7FF;
  localparam logic [ACC_CNT_W-1:0] EMIT_MIN = ACC_CNT_W'(CH_W - BYTE_W);

  localparam logic [CFG_IDX_W-1:0] CFG_START_NORMAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_NORMAL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_INVERTED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_INVERTED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_LOW        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_HIGH       = 3'd5;

  localparam logic [BYTE_W-1:0] RST_START_NORMAL   = 8'd15;
  localparam logic [BYTE_W-1:0] RST_END_NORMAL     = 8'd0;
  localparam logic [BYTE_W-1:0] RST_START_INVERTED = 8'd240;
  localparam logic [BYTE_W-1:0] RST_END_INVERTED   = 8'd255;
  localparam logic [PWM_W-1:0]  RST_PWM_LOW        = 12'd988;
  localparam logic [PWM_W-1:0]  RST_PWM_HIGH       = 12'd2012;

  typedef enum logic {
    FS_IDLE,
    FS_READ
  } fsm_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_end;
  } in_t;

  typedef struct packed {
    logic              frame_ok;
    logic              polarity_inverted;
    logic [IDX_W-1:0]  channel_index;
    logic [CH_W-1:0]   channel_value;
    logic [PWM_W-1:0]  pwm_value;
    logic [BYTE_W-1:0] flags_value;
    logic              digital_ch17;
    logic              digital_ch18;
    logic              lost_frame;
    logic              fail_safe;
    logic              last_result;
  } out_t;

  typedef struct packed {
    logic go;
    logic bad;
    logic active;
    logic inv;
  } frame_evt_t;

  typedef struct packed {
    logic              valid;
    logic              is_flags;
    logic [BYTE_W-1:0] data;
  } rd_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [CH_W-1:0]  value;
    logic             last;
  } chan_t;

endpackage
`default_nettype wire

// ===== hdl/sbf_frame.sv =====
// Byte counter, frame check, body memory and its read sequencer.
`default_nettype none
module sbf_frame (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       accept,
  input  wire sbf_pkg::in_t               item,
  input  wire logic [sbf_pkg::BYTE_W-1:0] start_normal,
  input  wire logic [sbf_pkg::BYTE_W-1:0] end_normal,
  input  wire logic [sbf_pkg::BYTE_W-1:0] start_inverted,
  input  wire logic [sbf_pkg::BYTE_W-1:0] end_inverted,
  output sbf_pkg::frame_evt_t             evt,
  output sbf_pkg::rd_t                    rd
);

  logic [sbf_pkg::BYTE_W-1:0] body_mem [sbf_pkg::BODY_DEPTH];
  logic [sbf_pkg::CNT_W-1:0]  byte_count;
  logic [sbf_pkg::BYTE_W-1:0] first_byte;
  logic [sbf_pkg::BYTE_W-1:0] closing_byte;
  logic [sbf_pkg::BYTE_W-1:0] closing_now;
  logic                       full;
  logic                       match_normal;
  logic                       match_inverted;
  logic                       marked;
  logic                       go;
  logic                       mem_we;
  logic [sbf_pkg::ADDR_W-1:0] wr_addr;
  logic [sbf_pkg::ADDR_W-1:0] rd_addr;
  logic [sbf_pkg::ADDR_W-1:0] rd_addr_next;
  logic                       rd_en;
  logic                       inv;
  logic                       rd_valid;
  logic                       rd_flags;
  logic [sbf_pkg::BYTE_W-1:0] mem_q;
  sbf_pkg::fsm_state_t        state;
  sbf_pkg::fsm_state_t        state_next;

  assign full        = (byte_count >= sbf_pkg::CLOSE_POS);
  assign closing_now = (byte_count == sbf_pkg::CLOSE_POS) ? item.data_byte : closing_byte;
  assign match_normal   = full && (first_byte == start_normal) && (closing_now == end_normal);
  assign match_inverted = full && (first_byte == start_inverted)
                          && (closing_now == end_inverted);
  assign marked  = accept && item.frame_end;
  assign go      = marked && (match_normal || match_inverted);
  assign mem_we  = accept && (byte_count != '0) && (byte_count <= sbf_pkg::BODY_LAST);
  assign wr_addr = ADDR_W_CAST(byte_count);

  function automatic logic [sbf_pkg::ADDR_W-1:0] ADDR_W_CAST(
    input logic [sbf_pkg::CNT_W-1:0] cnt
  );
    ADDR_W_CAST = sbf_pkg::ADDR_W'(cnt - 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      first_byte   <= '0;
      closing_byte <= '0;
    end else if (accept) begin
      if (byte_count == '0) begin
        first_byte <= item.data_byte;
      end else if (byte_count == sbf_pkg::CLOSE_POS) begin
        closing_byte <= item.data_byte;
      end
      if (item.frame_end) begin
        byte_count <= '0;
      end else if (byte_count < sbf_pkg::FULL_COUNT) begin
        byte_count <= byte_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      body_mem[wr_addr] <= item.data_byte;
    end
    mem_q <= body_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sbf_pkg::FS_IDLE: begin
        if (go) begin
          state_next = sbf_pkg::FS_READ;
        end
      end
      sbf_pkg::FS_READ: begin
        if (rd_addr == sbf_pkg::PAY_LAST) begin
          state_next = sbf_pkg::FS_IDLE;
        end
      end
      default: state_next = sbf_pkg::FS_IDLE;
    endcase
  end

  always_comb begin
    rd_en        = 1'b0;
    rd_addr_next = rd_addr;
    unique case (state)
      sbf_pkg::FS_IDLE: begin
        rd_addr_next = sbf_pkg::FLAGS_ADDR;
      end
      sbf_pkg::FS_READ: begin
        rd_en = 1'b1;
        if (rd_addr == sbf_pkg::FLAGS_ADDR) begin
          rd_addr_next = '0;
        end else begin
          rd_addr_next = rd_addr + 1'b1;
        end
      end
      default: rd_addr_next = sbf_pkg::FLAGS_ADDR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sbf_pkg::FS_IDLE;
      rd_addr  <= sbf_pkg::FLAGS_ADDR;
      rd_valid <= 1'b0;
      inv      <= 1'b0;
    end else begin
      state    <= state_next;
      rd_addr  <= rd_addr_next;
      rd_valid <= rd_en;
      if (go) begin
        inv <= !match_normal;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_flags <= (rd_addr == sbf_pkg::FLAGS_ADDR);
  end

  assign evt.go     = go;
  assign evt.bad    = marked && !(match_normal || match_inverted);
  assign evt.active = (state == sbf_pkg::FS_READ);
  assign evt.inv    = inv;

  assign rd.valid    = rd_valid;
  assign rd.is_flags = rd_flags;
  assign rd.data     = mem_q;

endmodule
`default_nettype wire

// ===== hdl/sbf_unpack.sv =====
// Bit accumulator that unpacks LSB-first channel values from payload bytes.
`default_nettype none
module sbf_unpack #(
  parameter int NUM_CHANNELS = sbf_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear,
  input  wire logic                       inv,
  input  wire sbf_pkg::rd_t               rd,
  output logic [sbf_pkg::BYTE_W-1:0]      flags,
  output sbf_pkg::chan_t                  chan
);

  logic [sbf_pkg::ACC_W-1:0]     acc;
  logic [sbf_pkg::ACC_CNT_W-1:0] acc_cnt;
  logic [sbf_pkg::CH_CNT_W-1:0]  ch_cnt;
  logic [sbf_pkg::BYTE_W-1:0]    d;
  logic [sbf_pkg::MERGE_W-1:0]   merged;
  logic                          take;
  logic                          emit;

  assign d      = rd.data ^ {sbf_pkg::BYTE_W{inv}};
  assign merged = {{(sbf_pkg::MERGE_W - sbf_pkg::ACC_W){1'b0}}, acc}
                  | ({{(sbf_pkg::MERGE_W - sbf_pkg::BYTE_W){1'b0}}, d} << acc_cnt);
  assign take   = rd.valid && !rd.is_flags;
  assign emit   = take && (acc_cnt >= sbf_pkg::EMIT_MIN);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc     <= '0;
      acc_cnt <= '0;
      ch_cnt  <= '0;
    end else if (take) begin
      if (emit) begin
        acc     <= sbf_pkg::ACC_W'(merged[sbf_pkg::MERGE_W-1:sbf_pkg::CH_W]);
        acc_cnt <= acc_cnt - sbf_pkg::EMIT_MIN;
        ch_cnt  <= ch_cnt + 1'b1;
      end else begin
        acc     <= merged[sbf_pkg::ACC_W-1:0];
        acc_cnt <= acc_cnt + sbf_pkg::ACC_CNT_W'(sbf_pkg::BYTE_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan.valid <= 1'b0;
    end else begin
      chan.valid <= emit && (ch_cnt < sbf_pkg::CH_CNT_W'(NUM_CHANNELS));
    end
  end

  always_ff @(posedge clk) begin
    chan.index <= ch_cnt[sbf_pkg::IDX_W-1:0];
    chan.value <= merged[sbf_pkg::CH_W-1:0];
    chan.last  <= (ch_cnt == sbf_pkg::CH_CNT_W'(NUM_CHANNELS - 1));
    if (rd.valid && rd.is_flags) begin
      flags <= d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sbf_scale.sv =====
// Channel to PWM scaling: registered multiply, then divide by 2047 with correction.
`default_nettype none
module sbf_scale (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire sbf_pkg::chan_t             chan,
  input  wire logic [sbf_pkg::PWM_W-1:0]  pwm_low,
  input  wire logic [sbf_pkg::PWM_W-1:0]  pwm_high,
  input  wire logic [sbf_pkg::BYTE_W-1:0] flags,
  input  wire logic                       inv,
  output logic                            valid,
  output sbf_pkg::out_t                   res
);

  sbf_pkg::chan_t              m_chan;
  logic [sbf_pkg::PROD_W-1:0]  m_prod;
  logic [sbf_pkg::PWM_W-1:0]   span;
  logic [sbf_pkg::PWM_W-1:0]   q0;
  logic [sbf_pkg::PWM_W:0]     rem;
  logic [sbf_pkg::PWM_W-1:0]   quot;
  logic                        ge1;
  logic                        ge2;

  assign span = (pwm_high > pwm_low) ? (pwm_high - pwm_low) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_chan.valid <= 1'b0;
    end else begin
      m_chan.valid <= chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    m_chan.index <= chan.index;
    m_chan.value <= chan.value;
    m_chan.last  <= chan.last;
    m_prod       <= sbf_pkg::PROD_W'(chan.value) * sbf_pkg::PROD_W'(span);
  end

  assign q0   = m_prod[sbf_pkg::PROD_W-1:sbf_pkg::CH_W];
  assign rem  = {1'b0, q0} + {2'b00, m_prod[sbf_pkg::CH_W-1:0]};
  assign ge1  = (rem >= (sbf_pkg::PWM_W + 1)'(sbf_pkg::CH_FULL));
  assign ge2  = (rem >= ((sbf_pkg::PWM_W + 1)'(sbf_pkg::CH_FULL) << 1));
  assign quot = q0 + sbf_pkg::PWM_W'(ge1) + sbf_pkg::PWM_W'(ge2);

  assign valid = m_chan.valid;

  always_comb begin
    res.frame_ok          = 1'b1;
    res.polarity_inverted = inv;
    res.channel_index     = m_chan.index;
    res.channel_value     = m_chan.value;
    res.pwm_value         = (m_chan.value == sbf_pkg::CH_FULL) ? pwm_high : (pwm_low + quot);
    res.flags_value       = flags;
    res.digital_ch17      = flags[0];
    res.digital_ch18      = flags[1];
    res.lost_frame        = flags[2];
    res.fail_safe         = flags[3];
    res.last_result       = m_chan.last;
  end

endmodule
`default_nettype wire

// ===== hdl/sbus_frame_decoder.sv =====
// Top level of the serial-bus frame decoder: configuration, result register, checks.
//
//   channel   signals                      direction  transfer
//   input     start, busy, item            in         start && !busy
//   config    wr_en, wr_index, wr_data     in         wr_en, every edge
//   result    done, result                 out        done, one cycle, no stall
//
// An unmarked byte is taken and busy stays low.
// A marked byte that fails the check gives its invalid result in the next cycle.
// A marked byte of a good frame holds busy over 23 reads of the body
// memory through its single read port (flags, then 22 payload bytes), then the
// unpack and multiply stages; results arrive one a cycle with short gaps, the last
// one on done in the first cycle with busy low.
// Synchronous reset clears the counter, sequencer and strobes; the results cannot stall.
`default_nettype none
module sbus_frame_decoder #(
  parameter int NUM_CHANNELS = sbf_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire sbf_pkg::in_t                  item,
  input  wire logic                          wr_en,
  input  wire logic [sbf_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [sbf_pkg::CFG_W-1:0]     wr_data,
  output logic                               done,
  output sbf_pkg::out_t                      result
);

  logic [sbf_pkg::BYTE_W-1:0] start_normal;
  logic [sbf_pkg::BYTE_W-1:0] end_normal;
  logic [sbf_pkg::BYTE_W-1:0] start_inverted;
  logic [sbf_pkg::BYTE_W-1:0] end_inverted;
  logic [sbf_pkg::PWM_W-1:0]  pwm_low;
  logic [sbf_pkg::PWM_W-1:0]  pwm_high;
  logic                       accept;
  sbf_pkg::frame_evt_t        evt;
  sbf_pkg::rd_t               rd;
  sbf_pkg::chan_t             chan;
  logic [sbf_pkg::BYTE_W-1:0] flags;
  logic                       sc_valid;
  sbf_pkg::out_t              sc_res;
  sbf_pkg::out_t              bad_res;

  assign accept = start && !busy;
  assign busy   = evt.active || rd.valid || chan.valid || sc_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_normal   <= sbf_pkg::RST_START_NORMAL;
      end_normal     <= sbf_pkg::RST_END_NORMAL;
      start_inverted <= sbf_pkg::RST_START_INVERTED;
      end_inverted   <= sbf_pkg::RST_END_INVERTED;
      pwm_low        <= sbf_pkg::RST_PWM_LOW;
      pwm_high       <= sbf_pkg::RST_PWM_HIGH;
    end else if (wr_en) begin
      unique case (wr_index)
        sbf_pkg::CFG_START_NORMAL:   start_normal   <= wr_data[sbf_pkg::BYTE_W-1:0];
        sbf_pkg::CFG_END_NORMAL:     end_normal     <= wr_data[sbf_pkg::BYTE_W-1:0];
        sbf_pkg::CFG_START_INVERTED: start_inverted <= wr_data[sbf_pkg::BYTE_W-1:0];
        sbf_pkg::CFG_END_INVERTED:   end_inverted   <= wr_data[sbf_pkg::BYTE_W-1:0];
        sbf_pkg::CFG_PWM_LOW:        pwm_low        <= wr_data;
        sbf_pkg::CFG_PWM_HIGH:       pwm_high       <= wr_data;
        default: ;
      endcase
    end
  end

  sbf_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .item           (item),
    .start_normal   (start_normal),
    .end_normal     (end_normal),
    .start_inverted (start_inverted),
    .end_inverted   (end_inverted),
    .evt            (evt),
    .rd             (rd)
  );

  sbf_unpack #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_unpack (
    .clk   (clk),
    .rst   (rst),
    .clear (evt.go),
    .inv   (evt.inv),
    .rd    (rd),
    .flags (flags),
    .chan  (chan)
  );

  sbf_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .chan     (chan),
    .pwm_low  (pwm_low),
    .pwm_high (pwm_high),
    .flags    (flags),
    .inv      (evt.inv),
    .valid    (sc_valid),
    .res      (sc_res)
  );

  always_comb begin
    bad_res             = '0;
    bad_res.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sc_valid || evt.bad;
    end
  end

  always_ff @(posedge clk) begin
    result <= evt.bad ? bad_res : sc_res;
  end

  a_bad_is_single: assert property (@(posedge clk) disable iff (rst)
    done && !result.frame_ok |-> result.last_result && (result.channel_index == '0))
    else $error("invalid transaction not a lone zeroed result");

  a_frame_holds_busy: assert property (@(posedge clk) disable iff (rst)
    done && result.frame_ok && !result.last_result |-> busy)
    else $error("busy dropped before the frame's last result");

  a_busy_from_mark: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && item.frame_end))
    else $error("busy rose without a marked byte");

  a_pwm_saturates: assert property (@(posedge clk) disable iff (rst)
    done && result.frame_ok && (result.channel_value == sbf_pkg::CH_FULL)
    |-> result.pwm_value == pwm_high)
    else $error("full-scale channel not saturated to pwm_high");

endmodule
`default_nettype wire

// ===== sim/tb_sbus_frame_decoder.sv =====
// Self-checking testbench for the serial-bus frame decoder: byte stream in, channel results checked.
`timescale 1ns / 100ps
`default_nettype none
module tb_sbus_frame_decoder;
  import sbf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 100;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM, FILL_MIXED} fill_t;
  typedef enum int {
    FK_GOOD, FK_LONG, FK_SHORT, FK_BAD_START, FK_BAD_END, FK_NOISE
  } frame_kind_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_t                  item;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;
  logic                 done;
  out_t                 result;

  sbus_frame_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .done     (done),
    .result   (result)
  );

  logic [BYTE_W-1:0] cfg_start_norm, cfg_end_norm, cfg_start_inv, cfg_end_inv;
  logic [PWM_W-1:0]  cfg_pwm_low, cfg_pwm_high;
  int                frm_count;
  logic [BYTE_W-1:0] frm_first, frm_close;
  logic [BYTE_W-1:0] frm_body [BODY_DEPTH];

  out_t              expected_channels [$];
  logic [BYTE_W-1:0] frame_buf [$];
  int                items_sent;
  int                fail_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [PWM_W-1:0] scale_to_pwm(logic [CH_W-1:0] v);
    int unsigned span;
    span = (cfg_pwm_high > cfg_pwm_low) ? (cfg_pwm_high - cfg_pwm_low) : 0;
    if (v == CH_FULL) return cfg_pwm_high;
    return PWM_W'(cfg_pwm_low + (v * span) / 2047);
  endfunction

  function automatic void predict_channels(in_t it);
    out_t              r;
    logic [BYTE_W-1:0] pay [PAYLOAD_BYTES];
    logic [BYTE_W-1:0] flg, xm;
    logic [CH_W-1:0]   v;
    logic              inv;
    int                bi;
    if (frm_count == 0) frm_first = it.data_byte;
    else if (frm_count <= BODY_DEPTH) frm_body[frm_count-1] = it.data_byte;
    else if (frm_count == FRAME_BYTES - 1) frm_close = it.data_byte;
    if (frm_count < FRAME_BYTES) frm_count++;
    if (!it.frame_end) return;
    if (frm_count >= FRAME_BYTES && frm_first == cfg_start_norm && frm_close == cfg_end_norm) begin
      inv = 1'b0;
    end else if (frm_count >= FRAME_BYTES && frm_first == cfg_start_inv &&
                 frm_close == cfg_end_inv) begin
      inv = 1'b1;
    end else begin
      frm_count = 0;
      r = '0;
      r.last_result = 1'b1;
      expected_channels.push_back(r);
      return;
    end
    frm_count = 0;
    xm = inv ? 8'hFF : 8'h00;
    for (int k = 0; k < PAYLOAD_BYTES; k++) pay[k] = frm_body[k] ^ xm;
    flg = frm_body[PAYLOAD_BYTES] ^ xm;
    for (int ch = 0; ch < NUM_CHANNELS_DEF; ch++) begin
      for (int k = 0; k < CH_W; k++) begin
        bi = ch * CH_W + k;
        v[k] = pay[bi >> 3][bi & 7];
      end
      r.frame_ok          = 1'b1;
      r.polarity_inverted = inv;
      r.channel_index     = IDX_W'(ch);
      r.channel_value     = v;
      r.pwm_value         = scale_to_pwm(v);
      r.flags_value       = flg;
      r.digital_ch17      = flg[0];
      r.digital_ch18      = flg[1];
      r.lost_frame        = flg[2];
      r.fail_safe         = flg[3];
      r.last_result       = (ch == NUM_CHANNELS_DEF - 1);
      expected_channels.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, logic [PWM_W-1:0] want,
                                      logic [PWM_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      if (expected_channels.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none, got %h", $time, result);
        fail_count++;
      end else begin
        want = expected_channels.pop_front();
        check_field("frame_ok", want.frame_ok, result.frame_ok);
        check_field("polarity_inverted", want.polarity_inverted, result.polarity_inverted);
        check_field("channel_index", want.channel_index, result.channel_index);
        check_field("channel_value", want.channel_value, result.channel_value);
        check_field("pwm_value", want.pwm_value, result.pwm_value);
        check_field("flags_value", want.flags_value, result.flags_value);
        check_field("digital_ch17", want.digital_ch17, result.digital_ch17);
        check_field("digital_ch18", want.digital_ch18, result.digital_ch18);
        check_field("lost_frame", want.lost_frame, result.lost_frame);
        check_field("fail_safe", want.fail_safe, result.fail_safe);
        check_field("last_result", want.last_result, result.last_result);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  task automatic send_byte(logic [BYTE_W-1:0] data, logic mark);
    in_t it;
    it.data_byte = data;
    it.frame_end = mark;
    @(negedge clk);
    start = 1'b1;
    item  = it;
    do begin
      @(posedge clk);
    end while (busy);
    predict_channels(it);
    items_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    start = 1'b0;
    while (expected_channels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = data;
    @(posedge clk);
    case (idx)
      CFG_START_NORMAL:   cfg_start_norm = data[BYTE_W-1:0];
      CFG_END_NORMAL:     cfg_end_norm   = data[BYTE_W-1:0];
      CFG_START_INVERTED: cfg_start_inv  = data[BYTE_W-1:0];
      CFG_END_INVERTED:   cfg_end_inv    = data[BYTE_W-1:0];
      CFG_PWM_LOW:        cfg_pwm_low    = data;
      CFG_PWM_HIGH:       cfg_pwm_high   = data;
      default: ;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] fill_byte(fill_t fill);
    case (fill)
      FILL_ZERO:   return 8'h00;
      FILL_ONES:   return 8'hFF;
      FILL_RANDOM: return BYTE_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 8'h00;
          1:       return 8'hFF;
          default: return BYTE_W'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic fill_frame(logic [BYTE_W-1:0] first_b, logic [BYTE_W-1:0] close_b,
                            int len, fill_t fill);
    frame_buf.delete();
    for (int i = 0; i < len; i++) begin
      if (i == 0) frame_buf.push_back(first_b);
      else if (i == FRAME_BYTES - 1) frame_buf.push_back(close_b);
      else frame_buf.push_back(fill_byte(fill));
    end
  endtask

  task automatic send_frame();
    bit gappy;
    gappy = ($urandom_range(0, 9) < 7);
    foreach (frame_buf[i]) begin
      if (gappy) idle(pick_gap());
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic send_kind(frame_kind_t kind, fill_t fill);
    logic [BYTE_W-1:0] s, e;
    bit inv;
    inv = 1'($urandom_range(0, 1));
    s = inv ? cfg_start_inv : cfg_start_norm;
    e = inv ? cfg_end_inv : cfg_end_norm;
    case (kind)
      FK_GOOD:      fill_frame(s, e, FRAME_BYTES, fill);
      FK_LONG:      fill_frame(s, e, $urandom_range(FRAME_BYTES + 1, 40), fill);
      FK_SHORT:     fill_frame(s, e, $urandom_range(1, FRAME_BYTES - 1), fill);
      FK_BAD_START: fill_frame(BYTE_W'($urandom), e, $urandom_range(FRAME_BYTES, 30), fill);
      FK_BAD_END:   fill_frame(s, BYTE_W'($urandom), $urandom_range(FRAME_BYTES, 30), fill);
      default: begin
        frame_buf.delete();
        repeat ($urandom_range(1, 40)) frame_buf.push_back(BYTE_W'($urandom));
      end
    endcase
    if (kind == FK_NOISE) begin
      foreach (frame_buf[i]) begin
        idle(pick_gap());
        send_byte(frame_buf[i], $urandom_range(0, 7) == 0);
      end
    end else begin
      send_frame();
    end
  endtask

  task automatic send_polarity(bit inv, int len, fill_t fill);
    if (inv) fill_frame(cfg_start_inv, cfg_end_inv, len, fill);
    else fill_frame(cfg_start_norm, cfg_end_norm, len, fill);
    send_frame();
  endtask

  task automatic random_config();
    int r;
    logic [BYTE_W-1:0] sn, en;
    logic [PWM_W-1:0] a, b;
    sn = BYTE_W'($urandom);
    en = BYTE_W'($urandom);
    write_reg(CFG_START_NORMAL, {4'($urandom), sn});
    write_reg(CFG_END_NORMAL, {4'($urandom), en});
    if ($urandom_range(0, 4) == 0) begin
      write_reg(CFG_START_INVERTED, CFG_W'(sn));
      write_reg(CFG_END_INVERTED, CFG_W'(en));
    end else begin
      write_reg(CFG_START_INVERTED, CFG_W'($urandom));
      write_reg(CFG_END_INVERTED, CFG_W'($urandom));
    end
    a = PWM_W'($urandom);
    b = PWM_W'($urandom);
    r = $urandom_range(0, 19);
    if (r < 14) begin
      write_reg(CFG_PWM_LOW, (a < b) ? a : b);
      write_reg(CFG_PWM_HIGH, (a < b) ? b : a);
    end else if (r < 17) begin
      write_reg(CFG_PWM_LOW, (a < b) ? b : a);
      write_reg(CFG_PWM_HIGH, (a < b) ? a : b);
    end else begin
      write_reg(CFG_PWM_LOW, '0);
      write_reg(CFG_PWM_HIGH, '1);
    end
  endtask

  task automatic test_default_frames();
    send_polarity(1'b0, FRAME_BYTES, FILL_ONES);
    send_polarity(1'b1, FRAME_BYTES, FILL_ZERO);
    send_polarity(1'b0, FRAME_BYTES, FILL_RANDOM);
    send_polarity(1'b0, 1, FILL_RANDOM);
    send_polarity(1'b1, FRAME_BYTES - 1, FILL_RANDOM);
    send_polarity(1'b0, FRAME_BYTES + 2, FILL_MIXED);
    send_kind(FK_BAD_END, FILL_RANDOM);
    quiesce();
  endtask

  task automatic test_spare_registers();
    write_reg(CFG_SPARE_6, CFG_W'($urandom));
    write_reg(CFG_SPARE_7, CFG_W'($urandom));
    send_polarity(1'b0, FRAME_BYTES, FILL_MIXED);
    send_polarity(1'b1, FRAME_BYTES, FILL_MIXED);
    quiesce();
  endtask

  task automatic test_polarity_overlap();
    write_reg(CFG_START_INVERTED, CFG_W'(cfg_start_norm));
    write_reg(CFG_END_INVERTED, CFG_W'(cfg_end_norm));
    send_polarity(1'b0, FRAME_BYTES, FILL_ONES);
    send_polarity(1'b1, FRAME_BYTES, FILL_MIXED);
    quiesce();
  endtask

  task automatic test_byte_extremes();
    write_reg(CFG_START_NORMAL, 12'hF00);
    write_reg(CFG_END_NORMAL, 12'hFFF);
    write_reg(CFG_START_INVERTED, 12'h0FF);
    write_reg(CFG_END_INVERTED, 12'h000);
    send_polarity(1'b0, FRAME_BYTES, FILL_MIXED);
    send_polarity(1'b1, FRAME_BYTES, FILL_MIXED);
    quiesce();
  endtask

  task automatic test_pwm_extremes();
    logic [PWM_W-1:0] lows [5]  = '{12'd0, 12'd4095, 12'd2048, 12'd0, 12'd4094};
    logic [PWM_W-1:0] highs [5] = '{12'd4095, 12'd0, 12'd2048, 12'd1, 12'd4095};
    for (int i = 0; i < 5; i++) begin
      write_reg(CFG_PWM_LOW, lows[i]);
      write_reg(CFG_PWM_HIGH, highs[i]);
      send_polarity(i[0], FRAME_BYTES, FILL_MIXED);
      quiesce();
    end
  endtask

  task automatic test_random_traffic();
    int base, r, frames_left;
    frame_kind_t kind;
    base = items_sent;
    frames_left = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (frames_left == 0) begin
        quiesce();
        random_config();
        frames_left = $urandom_range(3, 6);
      end
      r = $urandom_range(0, 99);
      if (r < 55) kind = FK_GOOD;
      else if (r < 65) kind = FK_LONG;
      else if (r < 75) kind = FK_SHORT;
      else if (r < 82) kind = FK_BAD_START;
      else if (r < 89) kind = FK_BAD_END;
      else kind = FK_NOISE;
      send_kind(kind, ($urandom_range(0, 1) == 0) ? FILL_RANDOM : FILL_MIXED);
      frames_left--;
    end
    quiesce();
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    item     = '0;
    wr_en    = 1'b0;
    wr_index = '0;
    wr_data  = '0;
    items_sent = 0;
    fail_count = 0;
    cfg_start_norm = RST_START_NORMAL;
    cfg_end_norm   = RST_END_NORMAL;
    cfg_start_inv  = RST_START_INVERTED;
    cfg_end_inv    = RST_END_INVERTED;
    cfg_pwm_low    = RST_PWM_LOW;
    cfg_pwm_high   = RST_PWM_HIGH;
    frm_count = 0;
    frm_first = '0;
    frm_close = '0;
    foreach (frm_body[i]) frm_body[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_default_frames();
    test_spare_registers();
    test_polarity_overlap();
    test_byte_extremes();
    test_pwm_extremes();
    test_random_traffic();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
